@@ src/pnf_pkg.sv @@
// pnf_pkg: types, codes, widths and character helpers for the number formatter
// no dependencies; used by pnf_div_unit, pnf_char_gen and printf_number_formatter
`default_nettype none

package pnf_pkg;

    // request and result widths
    localparam int VALUE_W     = 32;
    localparam int OPCODE_W    = 3;
    localparam int FW_W        = 6;
    localparam int PM_W        = 2;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 8;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;

    // tdata bit positions of the request fields
    localparam int OPCODE_LSB  = 0;
    localparam int VALUE_LSB   = OPCODE_LSB + OPCODE_W;
    localparam int FW_LSB      = VALUE_LSB + VALUE_W;
    localparam int PM_LSB      = FW_LSB + FW_W;

    localparam int MAX_WIDTH_DEF = 32;
    localparam int MAX_DIGITS    = 10;
    localparam int DIG_IDX_W     = $clog2(MAX_DIGITS);
    localparam int PLEN_W        = 3;

    // conversion kinds
    localparam logic [OPCODE_W-1:0] OP_CHAR  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SDEC  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_UDEC  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_HEXU  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_HEXL  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_PTR   = 3'd5;

    // padding modes
    localparam logic [PM_W-1:0] PM_LEAD_SPACE  = 2'd0;
    localparam logic [PM_W-1:0] PM_TRAIL_SPACE = 2'd1;
    localparam logic [PM_W-1:0] PM_LEAD_ZERO   = 2'd2;

    // ascii
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
    localparam logic [CHAR_W-1:0] CH_L      = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_PLAN,
        ST_CHAR,
        ST_PAD_LEAD,
        ST_PREFIX,
        ST_DIGITS,
        ST_PAD_TRAIL
    } state_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX,
        PFX_NIL
    } prefix_t;

    // what the character generator needs to pick the current character
    typedef struct packed {
        state_t               phase;
        prefix_t              pfx;
        logic [PLEN_W-1:0]    idx;
        logic [DIGIT_W-1:0]   digit;
        logic                 lower;
        logic                 zero_pad;
        logic [CHAR_W-1:0]    raw;
    } emit_sel_t;

    function automatic logic [PLEN_W-1:0] prefix_len(input prefix_t p);
        logic [PLEN_W-1:0] len;
        begin
            unique case (p)
                PFX_MINUS: len = 3'd1;
                PFX_HEX:   len = 3'd2;
                PFX_NIL:   len = 3'd5;
                default:   len = 3'd0;
            endcase
            return len;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] c;
        begin
            if (d < 4'd10)
                c = CH_ZERO + {4'h0, d};
            else if (lower)
                c = CH_LO_A + {4'h0, d - 4'd10};
            else
                c = CH_UP_A + {4'h0, d - 4'd10};
            return c;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] nil_char(input logic [PLEN_W-1:0] i);
        logic [CHAR_W-1:0] c;
        begin
            unique case (i)
                3'd0:    c = CH_LPAREN;
                3'd1:    c = CH_N;
                3'd2:    c = CH_I;
                3'd3:    c = CH_L;
                3'd4:    c = CH_RPAREN;
                default: c = CH_SPACE;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/pnf_div_unit.sv @@
// pnf_div_unit: shared digit extractor, one divide by ten or sixteen per load
// depends on pnf_pkg
`default_nettype none

module pnf_div_unit (
    input  wire logic                         clk,
    input  wire logic                         load,
    input  wire logic                         hex,
    input  wire logic [pnf_pkg::VALUE_W-1:0]  n,
    output logic      [pnf_pkg::VALUE_W-1:0]  q,
    output logic      [pnf_pkg::DIGIT_W-1:0]  rem
);
    import pnf_pkg::*;

    // reciprocal of ten, exact for every 32-bit dividend with a shift of 35
    localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int                 RECIP_SH = 35;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   q_reg;
    logic [VALUE_W-1:0]   q_next;

    assign prod = n * RECIP_10;

    always_comb
    begin
        if (hex)
            q_next = {4'h0, n[VALUE_W-1:4]};
        else
            q_next = {{RECIP_SH-VALUE_W{1'b0}}, prod[2*VALUE_W-1:RECIP_SH]};
    end

    always_ff @(posedge clk)
    begin
        if (load)
            q_reg <= q_next;
    end

    // low four bits of n - 10*q are enough, the remainder is below sixteen
    always_comb
    begin
        if (hex)
            rem = n[DIGIT_W-1:0];
        else
            rem = n[DIGIT_W-1:0] - {q_reg[0], 3'b000} - {q_reg[2:0], 1'b0};
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ src/pnf_char_gen.sv @@
// pnf_char_gen: picks the output character for the current emit phase
// depends on pnf_pkg
`default_nettype none

module pnf_char_gen (
    input  wire pnf_pkg::emit_sel_t            sel,
    output logic      [pnf_pkg::CHAR_W-1:0]    out_char
);
    import pnf_pkg::*;

    always_comb
    begin
        unique case (sel.phase)
            ST_CHAR:      out_char = sel.raw;
            ST_PAD_LEAD:  out_char = sel.zero_pad ? CH_ZERO : CH_SPACE;
            ST_PREFIX:
            begin
                unique case (sel.pfx)
                    PFX_MINUS: out_char = CH_MINUS;
                    PFX_HEX:   out_char = (sel.idx == 3'd0) ? CH_ZERO : CH_X;
                    PFX_NIL:   out_char = nil_char(sel.idx);
                    default:   out_char = CH_SPACE;
                endcase
            end
            ST_DIGITS:    out_char = digit_char(sel.digit, sel.lower);
            ST_PAD_TRAIL: out_char = CH_SPACE;
            default:      out_char = CH_NUL;
        endcase
    end

endmodule

`default_nettype wire

@@ src/printf_number_formatter.sv @@
// printf_number_formatter: top level, request decode, sequencer and digit store
// depends on pnf_pkg, pnf_div_unit and pnf_char_gen
`default_nettype none

// Formats one integer conversion request into ASCII, one character per
// result, with tlast on the final character. A request carries a kind
// (char, signed decimal, unsigned decimal, upper hex, lower hex, pointer),
// a 32-bit value, a field width that saturates at MAX_WIDTH and a padding
// mode (leading spaces, trailing spaces, leading zeros; zeros go in front of
// a minus sign or 0x prefix). A zero pointer prints as (nil); kinds 6 and 7
// are accepted and produce nothing. Only one request is in flight: s_axis_tready
// is high only while the block is idle. Digits come from one shared divider
// that handles each digit in a divide step (a reciprocal multiply for decimal,
// a shift for hex) and then a remainder and write-back step. A zero pointer
// skips the divider. Characters leave at one per cycle while m_axis_tready
// stays high.

module printf_number_formatter #(
    parameter int MAX_WIDTH = pnf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // request: opcode[2:0], value[34:3], field_width[40:35], pad_mode[42:41]
    input  wire logic [pnf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // result: out_char[7:0]
    output logic      [pnf_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic                                  m_axis_tlast
);
    import pnf_pkg::*;

    // counters cover the padded field
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    // request fields
    logic [OPCODE_W-1:0] in_op;
    logic [VALUE_W-1:0]  in_value;
    logic [FW_W-1:0]     in_fw;
    logic [PM_W-1:0]     in_pm;

    assign in_op    = s_axis_tdata[OPCODE_LSB +: OPCODE_W];
    assign in_value = s_axis_tdata[VALUE_LSB +: VALUE_W];
    assign in_fw    = s_axis_tdata[FW_LSB +: FW_W];
    assign in_pm    = s_axis_tdata[PM_LSB +: PM_W];

    state_t                state_reg, state_next;
    prefix_t               pfx_reg, pfx_next;
    logic [VALUE_W-1:0]    n_reg, n_next;
    logic                  hex_reg, hex_next;
    logic                  lower_reg, lower_next;
    logic                  trail_reg, trail_next;
    logic                  zero_reg, zero_next;
    logic [CNT_W-1:0]      fw_reg, fw_next;
    logic [CNT_W-1:0]      pad_reg, pad_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIG_IDX_W-1:0]  ndig_reg, ndig_next;
    logic [DIGIT_W-1:0]    dig_reg [MAX_DIGITS];

    logic                  in_fire;
    logic                  out_fire;
    logic                  div_load;
    logic [VALUE_W-1:0]    div_q;
    logic [DIGIT_W-1:0]    div_rem;

    logic [PLEN_W-1:0]     plen;
    logic [DIG_IDX_W-1:0]  text_len;
    logic [CNT_W-1:0]      plan_pad;
    logic                  pad_last;
    logic                  pfx_last;
    logic                  dig_last;
    logic                  trail_pending;
    state_t                first_text_st;
    state_t                after_text_st;

    emit_sel_t             sel;
    logic [CHAR_W-1:0]     out_char;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // text length is prefix plus digits, at most eleven
    assign plen     = prefix_len(pfx_reg);
    assign text_len = DIG_IDX_W'(plen) + ndig_reg;
    assign plan_pad = (fw_reg > CNT_W'(text_len)) ? (fw_reg - CNT_W'(text_len)) : '0;

    assign pad_last      = (cnt_reg == pad_reg - CNT_W'(1));
    assign pfx_last      = (cnt_reg == CNT_W'(plen - 3'd1));
    assign dig_last      = (cnt_reg == '0);
    assign trail_pending = trail_reg && (pad_reg != '0);
    assign first_text_st = (pfx_reg != PFX_NONE) ? ST_PREFIX : ST_DIGITS;
    assign after_text_st = trail_pending ? ST_PAD_TRAIL : ST_IDLE;

    // shared divider
    pnf_div_unit u_div (
        .clk  (clk),
        .load (div_load),
        .hex  (hex_reg),
        .n    (n_reg),
        .q    (div_q),
        .rem  (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_op) inside
                        OP_CHAR:                           state_next = ST_CHAR;
                        OP_SDEC, OP_UDEC, OP_HEXU, OP_HEXL: state_next = ST_DIV;
                        OP_PTR:
                            state_next = (in_value == '0) ? ST_PLAN : ST_DIV;
                        default:                           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
                state_next = ST_STEP;
            ST_STEP:
                state_next = (div_q == '0) ? ST_PLAN : ST_DIV;
            ST_PLAN:
            begin
                if (!trail_reg && (plan_pad != '0))
                    state_next = ST_PAD_LEAD;
                else
                    state_next = first_text_st;
            end
            ST_CHAR:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            ST_PAD_LEAD:
            begin
                if (m_axis_tready && pad_last)
                    state_next = first_text_st;
            end
            ST_PREFIX:
            begin
                if (m_axis_tready && pfx_last)
                    state_next = (ndig_reg != '0) ? ST_DIGITS : after_text_st;
            end
            ST_DIGITS:
            begin
                if (m_axis_tready && dig_last)
                    state_next = after_text_st;
            end
            ST_PAD_TRAIL:
            begin
                if (m_axis_tready && pad_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // handshake and control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        m_axis_tlast  = 1'b0;
        div_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:      s_axis_tready = 1'b1;
            ST_DIV:       div_load      = 1'b1;
            ST_CHAR:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = 1'b1;
            end
            ST_PAD_LEAD:  m_axis_tvalid = 1'b1;
            ST_PREFIX:
            begin
                m_axis_tvalid = 1'b1;
                // only (nil) ends in its prefix
                m_axis_tlast  = pfx_last && (ndig_reg == '0) && !trail_pending;
            end
            ST_DIGITS:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = dig_last && !trail_pending;
            end
            ST_PAD_TRAIL:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = pad_last;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        pfx_next   = pfx_reg;
        n_next     = n_reg;
        hex_next   = hex_reg;
        lower_next = lower_reg;
        trail_next = trail_reg;
        zero_next  = zero_reg;
        fw_next    = fw_reg;
        pad_next   = pad_reg;
        ndig_next  = ndig_reg;
        cnt_next   = cnt_reg;

        if (in_fire)
        begin
            // magnitude for signed decimal, plain bits otherwise
            n_next     = ((in_op == OP_SDEC) && in_value[VALUE_W-1]) ? (VALUE_W'(0) - in_value)
                                                                    : in_value;
            hex_next   = (in_op == OP_HEXU) || (in_op == OP_HEXL) || (in_op == OP_PTR);
            lower_next = (in_op == OP_HEXL) || (in_op == OP_PTR);
            trail_next = (in_pm == PM_TRAIL_SPACE);
            zero_next  = (in_pm == PM_LEAD_ZERO);
            fw_next    = (in_fw > FW_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : CNT_W'(in_fw);
            ndig_next  = '0;
            if ((in_op == OP_SDEC) && in_value[VALUE_W-1])
                pfx_next = PFX_MINUS;
            else if (in_op == OP_PTR)
                pfx_next = (in_value == '0) ? PFX_NIL : PFX_HEX;
            else
                pfx_next = PFX_NONE;
        end

        if (state_reg == ST_STEP)
        begin
            n_next    = div_q;
            ndig_next = ndig_reg + DIG_IDX_W'(1);
        end

        if (state_reg == ST_PLAN)
            pad_next = plan_pad;

        // counters restart on a phase change, digits count down from the top
        if (state_next != state_reg)
            cnt_next = (state_next == ST_DIGITS) ? CNT_W'(ndig_reg - DIG_IDX_W'(1)) : '0;
        else if (out_fire)
            cnt_next = (state_reg == ST_DIGITS) ? (cnt_reg - CNT_W'(1))
                                                : (cnt_reg + CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        pfx_reg   <= pfx_next;
        n_reg     <= n_next;
        hex_reg   <= hex_next;
        lower_reg <= lower_next;
        trail_reg <= trail_next;
        zero_reg  <= zero_next;
        fw_reg    <= fw_next;
        pad_reg   <= pad_next;
        ndig_reg  <= ndig_next;
        cnt_reg   <= cnt_next;
        if (state_reg == ST_STEP)
            dig_reg[ndig_reg] <= div_rem;
    end

    // character selection
    always_comb
    begin
        sel.phase    = state_reg;
        sel.pfx      = pfx_reg;
        sel.idx      = cnt_reg[PLEN_W-1:0];
        sel.digit    = dig_reg[cnt_reg[DIG_IDX_W-1:0]];
        sel.lower    = lower_reg;
        sel.zero_pad = zero_reg;
        sel.raw      = n_reg[CHAR_W-1:0];
    end

    pnf_char_gen u_char (
        .sel      (sel),
        .out_char (out_char)
    );

    assign m_axis_tdata = out_char;

    // one request at a time: never ready while a character is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request accepted while a result is pending");

    // the digit store never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (ndig_reg < DIG_IDX_W'(MAX_DIGITS)))
        else $error("digit store overflow");

    // after the final character the block is idle again
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after last character");

    // a char request gives a single last character on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata[2:0] == OP_CHAR))
        |=> (m_axis_tvalid && m_axis_tlast))
        else $error("char request did not produce one last character");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench for printf_number_formatter, directed and random requests
// depends on pnf_pkg and the formatter rtl; characters are checked against a behavioral formatter

module tb;
    import pnf_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int FMT_MAX_WIDTH   = 32;
    // decode, the divider steps for ten digits and a full field, rounded up
    localparam int DRAIN_CYCLES    = 64;
    localparam int RANDOM_REQUESTS = 290;
    localparam int HOLD_LEN        = 300;

    // kinds and pad mode that the package leaves unnamed
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
    localparam logic [PM_W-1:0]     PM_SPARE   = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
        logic [FW_W-1:0]     field_width;
        logic [PM_W-1:0]     pad_mode;
    } fmt_request_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } fmt_char_t;

    typedef logic [CHAR_W-1:0] text_t[$];

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 m_axis_tlast;

    fmt_request_t pending_requests[$];   // requests not yet offered
    fmt_char_t    expected_chars[$];     // characters still owed by the block
    fmt_request_t on_bus;                // request currently offered on the slave side
    fmt_char_t    due;
    int           requests_accepted = 0;
    int           mismatches = 0;
    int           tx_gap = 0;
    int           rx_gap = 0;
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;
    int           hold_cycles = 0;
    int           holds_done = 0;

    printf_number_formatter #(
        .MAX_WIDTH(FMT_MAX_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // behavioral formatter
    // ------------------------------------------------------------------

    function automatic logic [S_TDATA_W-1:0] pack_request(input fmt_request_t r);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[OPCODE_LSB +: OPCODE_W] = r.opcode;
        d[VALUE_LSB +: VALUE_W]   = r.value;
        d[FW_LSB +: FW_W]         = r.field_width;
        d[PM_LSB +: PM_W]         = r.pad_mode;
        return d;
    endfunction

    // digits of n in the given base, most significant first; zero gives one digit
    function automatic text_t digits_of(input logic [VALUE_W-1:0] n, input int unsigned base,
                                        input bit lower);
        text_t       t;
        int unsigned d;
        do
        begin
            d = n % base;
            if (d < 10)
                t.push_front("0" + 8'(d));
            else if (lower)
                t.push_front("a" + 8'(d - 10));
            else
                t.push_front("A" + 8'(d - 10));
            n = n / base;
        end
        while (n != 0);
        return t;
    endfunction

    // appends the characters that one accepted request must produce
    function automatic void predict_chars(input fmt_request_t r);
        text_t             txt;
        int                width;
        int                pad;
        logic [CHAR_W-1:0] fill;
        fmt_char_t         c;
        width = (r.field_width > FMT_MAX_WIDTH) ? FMT_MAX_WIDTH : int'(r.field_width);
        case (r.opcode)
            OP_CHAR:
            begin
                // a character ignores width and padding
                txt.push_back(r.value[7:0]);
                width = 0;
            end
            OP_SDEC:
            begin
                if (r.value[VALUE_W-1])
                begin
                    txt = digits_of(32'd0 - r.value, 10, 1'b0);
                    txt.push_front("-");
                end
                else
                begin
                    txt = digits_of(r.value, 10, 1'b0);
                end
            end
            OP_UDEC: txt = digits_of(r.value, 10, 1'b0);
            OP_HEXU: txt = digits_of(r.value, 16, 1'b0);
            OP_HEXL: txt = digits_of(r.value, 16, 1'b1);
            OP_PTR:
            begin
                if (r.value == '0)
                begin
                    txt = '{"(", "n", "i", "l", ")"};
                end
                else
                begin
                    txt = digits_of(r.value, 16, 1'b1);
                    txt.push_front("x");
                    txt.push_front("0");
                end
            end
            default: return;   // spare kinds emit nothing
        endcase
        pad = width - txt.size();
        if (pad < 0)
            pad = 0;
        // zero fill goes ahead of everything, sign and 0x prefix included
        fill = (r.pad_mode == PM_LEAD_ZERO) ? "0" : " ";
        if (r.pad_mode == PM_TRAIL_SPACE)
            repeat (pad) txt.push_back(" ");
        else
            repeat (pad) txt.push_front(fill);
        foreach (txt[i])
        begin
            c.ch   = txt[i];
            c.last = (i == txt.size() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly no idle, some short gaps, a few long ones; steady stretches have none
    function automatic int idle_cycles(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // values weighted toward zero, sign boundaries, powers of two and small numbers
    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000 + $urandom_range(0, 15);
            3:       return $urandom_range(0, 99);
            4:       return 32'd1 << $urandom_range(0, 31);
            5:       return 32'd0 - $urandom_range(1, 99);
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_request(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v,
                                        input logic [FW_W-1:0] fw, input logic [PM_W-1:0] pm);
        fmt_request_t r;
        r.opcode      = op;
        r.value       = v;
        r.field_width = fw;
        r.pad_mode    = pm;
        pending_requests.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // request driver: offers queued requests, predicts on acceptance
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_gap        <= 0;
            tx_steady     <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_chars(on_bus);
                requests_accepted <= requests_accepted + 1;
            end
            // the bus slot is free when nothing is offered or the offer was just taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    on_bus = pending_requests.pop_front();
                    s_axis_tdata  <= pack_request(on_bus);
                    s_axis_tvalid <= 1'b1;
                    tx_gap        <= idle_cycles(tx_steady);
                    if ($urandom_range(0, 24) == 0)
                        tx_steady <= !tx_steady;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // long receiver hold-offs: the block backs up and stalls its input
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            holds_done  <= 0;
        end
        else if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
        else if (holds_done < 2 && requests_accepted >= 40 + 130 * holds_done)
        begin
            hold_cycles <= HOLD_LEN;
            holds_done  <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------
    // character monitor: random ready, compares against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap        <= 0;
            rx_steady     <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character 0x%02h (tlast %0b) with nothing pending",
                           m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    due = expected_chars.pop_front();
                    if (m_axis_tdata !== due.ch)
                    begin
                        $error("out_char mismatch: expected 0x%02h, got 0x%02h",
                               due.ch, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== due.last)
                    begin
                        $error("last mismatch: expected %0b, got %0b", due.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            if (hold_cycles != 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                rx_gap        <= rx_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_gap        <= idle_cycles(rx_steady);
                if ($urandom_range(0, 39) == 0)
                    rx_steady <= !rx_steady;
            end
        end
    end

    // ------------------------------------------------------------------
    // request list, reset and end of run
    // ------------------------------------------------------------------

    initial
    begin
        fmt_request_t req;
        int           counted;
        int           r;
        int           total;

        // directed requests: field extremes, every kind and the corner cases
        add_request(OP_CHAR, 32'h0000_0000, 6'd32, PM_LEAD_ZERO);    // char ignores width
        add_request(OP_CHAR, 32'hFFFF_FFFF, 6'd5,  PM_TRAIL_SPACE);
        add_request(OP_SDEC, 32'h0000_0000, 6'd0,  PM_LEAD_SPACE);   // zero prints one digit
        add_request(OP_SDEC, 32'h8000_0000, 6'd12, PM_LEAD_ZERO);    // most negative, zero before sign
        add_request(OP_SDEC, 32'hFFFF_FFFF, 6'd5,  PM_TRAIL_SPACE);
        add_request(OP_SDEC, 32'h7FFF_FFFF, 6'd63, PM_LEAD_SPACE);   // wide field saturates
        add_request(OP_SDEC, 32'h8000_0001, 6'd32, PM_TRAIL_SPACE);
        add_request(OP_UDEC, 32'hFFFF_FFFF, 6'd10, PM_LEAD_ZERO);    // text exactly fills the field
        add_request(OP_UDEC, 32'h0000_0000, 6'd32, PM_TRAIL_SPACE);
        add_request(OP_UDEC, 32'd1234567890, 6'd31, PM_LEAD_SPACE);
        add_request(OP_HEXU, 32'hDEAD_BEEF, 6'd0,  PM_SPARE);        // spare pad mode acts as spaces
        add_request(OP_HEXU, 32'h0000_000A, 6'd33, PM_SPARE);
        add_request(OP_HEXL, 32'hABCD_EF01, 6'd40, PM_LEAD_ZERO);
        add_request(OP_HEXL, 32'h0000_0000, 6'd1,  PM_LEAD_SPACE);
        add_request(OP_PTR,  32'h0000_0000, 6'd8,  PM_LEAD_ZERO);    // null pointer text
        add_request(OP_PTR,  32'h0000_0000, 6'd0,  PM_TRAIL_SPACE);
        add_request(OP_PTR,  32'hFFFF_FFFF, 6'd33, PM_TRAIL_SPACE);
        add_request(OP_PTR,  32'h0000_0001, 6'd4,  PM_LEAD_ZERO);    // zeros ahead of 0x
        add_request(OP_SPARE_6, 32'h1234_5678, 6'd10, PM_LEAD_SPACE); // no output at all
        add_request(OP_SPARE_7, 32'hFFFF_FFFF, 6'd63, PM_SPARE);

        // random requests; spare kinds are sprinkled in but not counted
        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 24) == 0)
                req.opcode = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            else
                req.opcode = OPCODE_W'($urandom_range(OP_CHAR, OP_PTR));
            req.value = random_value();
            r = $urandom_range(0, 99);
            if (r < 70)
                req.field_width = FW_W'($urandom_range(0, 16));
            else if (r < 90)
                req.field_width = FW_W'($urandom_range(17, FMT_MAX_WIDTH));
            else
                req.field_width = FW_W'($urandom_range(FMT_MAX_WIDTH + 1, 63));
            req.pad_mode = PM_W'($urandom_range(PM_LEAD_SPACE, PM_SPARE));
            pending_requests.push_back(req);
            if (req.opcode <= OP_PTR)
                counted++;
        end
        total = pending_requests.size();

        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // every request accepted and its characters predicted
        while (requests_accepted < total)
            @(posedge clk);
        // every character delivered, then room for anything extra to show up
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[printf_number_formatter] OK");
        else
            $display("[printf_number_formatter] ERROR");
        $finish;
    end

    // watchdog: far beyond the slowest legal run with every character stalled
    initial
    begin
        #20ms;
        $display("[printf_number_formatter] ERROR");
        $finish;
    end

endmodule
